>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cds_pkg.sv
// ---------------------------------------------------------------------------
// Calendar date stepper package
// Types, command codes and calendar helper functions.
// ---------------------------------------------------------------------------
package cds_pkg;

   typedef logic [4:0]  day_type;
   typedef logic [3:0]  month_type;
   typedef logic [13:0] year_type;

   // last year a date may reach
   localparam year_type MAX_YEAR = 14'd9999;

   // Zeller's year split: floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;

   typedef enum logic [2:0] {
      CMD_LOAD      = 3'd0,
      CMD_BACK_WEEK = 3'd1,
      CMD_FWD_WEEK  = 3'd2,
      CMD_BACK_DAY  = 3'd3,
      CMD_FWD_DAY   = 3'd4
   } command_type;

   typedef struct packed {
      day_type   day;
      month_type month;
      year_type  year;
   } date_type;

   // days in month; leap year every fourth year
   function automatic day_type days_in(input month_type m, input year_type y);
      day_type len;
      len = 5'd31;
      if (m == 4'd2) begin
         len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
         len = 5'd30;
      end
      return len;
   endfunction

   // (13 * mm - 1) / 5 with March as month one of the shifted year
   function automatic logic [4:0] month_term(input month_type m);
      logic [4:0] t;
      unique case (m)
         4'd1:    t = 5'd28;
         4'd2:    t = 5'd31;
         4'd3:    t = 5'd2;
         4'd4:    t = 5'd5;
         4'd5:    t = 5'd7;
         4'd6:    t = 5'd10;
         4'd7:    t = 5'd12;
         4'd8:    t = 5'd15;
         4'd9:    t = 5'd18;
         4'd10:   t = 5'd20;
         4'd11:   t = 5'd23;
         4'd12:   t = 5'd25;
         default: t = 5'd0;
      endcase
      return t;
   endfunction

   // residue modulo 7: octal digits add up since 8 = 1 mod 7
   function automatic logic [2:0] mod7(input logic [10:0] f);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(f[2:0]) + 5'(f[5:3]) + 5'(f[8:6]) + 5'(f[10:9]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      if (s2 >= 4'd7) begin
         s2 = s2 - 4'd7;
      end
      return s2[2:0];
   endfunction

endpackage

>>> design/calendar_date_stepper.sv
// ---------------------------------------------------------------------------
// Calendar date stepper
// Holds a date, applies load / week / day step requests and reports the
// date with its weekday, first weekday of the month and month length.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on req_*: tuser carries the command, tdata the date to
//   load (only used by a load). Each request gives exactly one response on
//   rsp_*: tdata the resulting date, weekdays and month length, tuser the
//   reject flag. A refused load or a step past 1 Jan of year 1 or
//   31 Dec of MAX_YEAR leaves the date as it was.
//   From request acceptance to response valid, a request passes the date
//   register (loaded on acceptance), the year split stage (one 14 x 13
//   multiply) and the response register fed from the weekday logic.
//   Throughput is one request per cycle while the receiver does not stall;
//   the date update for a request is done in the cycle it is accepted, so
//   the next one may follow at once.
//   When the receiver stalls, the three stages fill up in turn and
//   req_tready drops only once every stage holds a request.
//   Reset (synchronous) sets the date to 1 Jan of year 1 and empties the
//   pipeline; no response is pending afterwards.
// ---------------------------------------------------------------------------
module calendar_date_stepper (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // new_day[4:0], new_month[8:5], new_year[22:9], pad
   input  logic [2:0]  req_tuser,   // command[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // day[4:0], month[8:5], year[22:9], weekday[25:23],
                                    // first_weekday[28:26], month_length[33:29], pad
   output logic        rsp_tuser    // rejected
);
   import cds_pkg::*;

   // handshake and stage flow
   logic        req_accept;
   logic        rsp_ready_int;
   logic        s2_ready;
   logic        s1_ready;
   logic        s1_move;
   logic        s2_move;

   // stage 1: current date (the block state)
   date_type    date_ff, date_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_rej_ff, s1_rej_in;

   // stage 2: year split
   logic        s2_valid_ff, s2_valid_in;
   date_type    s2_date_ff;
   logic        s2_rej_ff;
   year_type    s2_yy_ff;
   logic [7:0]  s2_hi_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff;
   logic        rsp_user_ff;

   // next date logic
   command_type      cmd;
   date_type         load_date;
   logic             load_ok;
   logic             is_move;
   logic signed [6:0] delta;
   logic signed [6:0] sum_day;
   month_type        prev_month, next_month;
   year_type         prev_year, next_year;
   day_type          cur_len, prev_len, load_len;

   // year split logic
   year_type         yy;
   logic [26:0]      yy_prod;

   // weekday logic
   logic [6:0]       lo;
   logic [9:0]       yterm;
   logic [9:0]       fbase;
   logic [10:0]      f_day;
   logic [10:0]      f_first;
   logic [2:0]       wd, first_wd;
   day_type          out_len;

   assign req_accept    = req_tvalid && req_tready;
   assign rsp_ready_int = !rsp_valid_ff || rsp_tready;
   assign s2_ready      = !s2_valid_ff || rsp_ready_int;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign s1_move       = s1_valid_ff && s2_ready;
   assign s2_move       = s2_valid_ff && rsp_ready_int;
   assign req_tready    = s1_ready;

   // request decode
   assign cmd       = command_type'(req_tuser);
   assign load_date = '{day: req_tdata[4:0], month: req_tdata[8:5], year: req_tdata[22:9]};
   assign load_len  = days_in(load_date.month, load_date.year);
   assign load_ok   = load_date.month >= 4'd1 && load_date.month <= 4'd12 &&
                      load_date.year >= 14'd1 && load_date.year <= MAX_YEAR &&
                      load_date.day >= 5'd1 && load_date.day <= load_len;

   // neighbor months of the current date
   assign prev_month = (date_ff.month == 4'd1) ? 4'd12 : date_ff.month - 4'd1;
   assign prev_year  = (date_ff.month == 4'd1) ? date_ff.year - 14'd1 : date_ff.year;
   assign next_month = (date_ff.month == 4'd12) ? 4'd1 : date_ff.month + 4'd1;
   assign next_year  = (date_ff.month == 4'd12) ? date_ff.year + 14'd1 : date_ff.year;
   assign cur_len    = days_in(date_ff.month, date_ff.year);
   assign prev_len   = days_in(prev_month, prev_year);
   assign sum_day    = $signed({2'b00, date_ff.day}) + delta;

   // step size per command
   always_comb begin
      delta   = 7'sd0;
      is_move = 1'b1;
      unique case (cmd)
         CMD_BACK_WEEK: delta = -7'sd7;
         CMD_FWD_WEEK:  delta = 7'sd7;
         CMD_BACK_DAY:  delta = -7'sd1;
         CMD_FWD_DAY:   delta = 7'sd1;
         default:       is_move = 1'b0;
      endcase
   end

   // next date and reject flag
   always_comb begin
      date_in   = date_ff;
      s1_rej_in = 1'b0;
      if (cmd == CMD_LOAD) begin
         if (load_ok) begin
            date_in = load_date;
         end else begin
            s1_rej_in = 1'b1;
         end
      end else if (!is_move) begin
         s1_rej_in = 1'b1;
      end else if (sum_day < 7'sd1) begin
         // borrow from the previous month
         if (date_ff.month == 4'd1 && date_ff.year <= 14'd1) begin
            s1_rej_in = 1'b1;
         end else begin
            date_in.day   = 5'(sum_day + $signed({2'b00, prev_len}));
            date_in.month = prev_month;
            date_in.year  = prev_year;
         end
      end else if (sum_day > $signed({2'b00, cur_len})) begin
         // carry into the next month
         if (date_ff.month == 4'd12 && date_ff.year >= MAX_YEAR) begin
            s1_rej_in = 1'b1;
         end else begin
            date_in.day   = 5'(sum_day - $signed({2'b00, cur_len}));
            date_in.month = next_month;
            date_in.year  = next_year;
         end
      end else begin
         date_in.day = 5'(sum_day);
      end
   end

   // stage valid bits
   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_move ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
   end

   // year split: Jan and Feb count in the previous year
   assign yy      = (date_ff.month <= 4'd2) ? date_ff.year - 14'd1 : date_ff.year;
   assign yy_prod = 27'(yy) * 27'(DIV100_MUL);

   // weekday from Zeller's congruence; -2 * century is +5 * century mod 7
   assign lo      = 7'(s2_yy_ff - 14'(s2_hi_ff) * 14'd100);
   assign yterm   = 10'(lo) + 10'(lo[6:2]) + 10'(s2_hi_ff[7:2]) + 10'(s2_hi_ff) * 10'd5;
   assign fbase   = yterm + 10'(month_term(s2_date_ff.month));
   assign f_day   = 11'(fbase) + 11'(s2_date_ff.day);
   assign f_first = 11'(fbase) + 11'd1;
   assign wd       = mod7(f_day);
   assign first_wd = mod7(f_first);
   assign out_len  = days_in(s2_date_ff.month, s2_date_ff.year);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff      <= '{day: 5'd1, month: 4'd1, year: 14'd1};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            date_ff <= date_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rej_ff <= s1_rej_in;
      end
      if (s1_move) begin
         s2_date_ff <= date_ff;
         s2_rej_ff  <= s1_rej_ff;
         s2_yy_ff   <= yy;
         s2_hi_ff   <= yy_prod[DIV100_SHIFT +: 8];
      end
      if (s2_move) begin
         rsp_data_ff <= {6'd0, out_len, first_wd, wd,
                         s2_date_ff.year, s2_date_ff.month, s2_date_ff.day};
         rsp_user_ff <= s2_rej_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_month_range,
      date_ff.month >= 4'd1 && date_ff.month <= 4'd12, "month out of range")
   `ASSERT_IMPLIES(a_day_fits, rsp_valid_ff,
      rsp_data_ff[4:0] != 5'd0 && rsp_data_ff[4:0] <= rsp_data_ff[33:29],
      "day beyond month length")
   `ASSERT_NEXT(a_reject_holds, req_accept && s1_rej_in, $stable(date_ff),
      "refused request changed date")

endmodule
